// ===== hw/rtl/bmirq_pkg.sv =====
// ----------------------------------------------------------------------------
// Bank mapper package
// Shared widths, address decode codes, request types and helper functions.
// ----------------------------------------------------------------------------
package bmirq_pkg;

    localparam int TICKS_PER_COUNT = 3;

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int CYC_W     = 4;
    localparam int CNT_W     = 16;
    localparam int NIB_W     = 4;
    localparam int BANK_W    = 8;
    localparam int PRG_BANKS = 3;
    localparam int CHR_BANKS = 8;
    localparam int CHR_IDX_W = 3;
    localparam int PAGE_W    = 9;
    localparam int MIRROR_W  = 2;
    localparam int WSEL_W    = 2;

    localparam logic [PAGE_W-1:0] PAGE_RESET = 9'd256;

    localparam int PRESCALE_W = (TICKS_PER_COUNT > 1) ? $clog2(TICKS_PER_COUNT) : 1;
    localparam int ACC_MAX    = (TICKS_PER_COUNT - 1) + ((1 << CYC_W) - 1);
    localparam int ACC_W      = $clog2(ACC_MAX + 1);
    localparam int UNITS_MAX  = ACC_MAX / TICKS_PER_COUNT;
    localparam int UNITS_W    = (UNITS_MAX > 1) ? $clog2(UNITS_MAX + 1) : 1;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 104;
    localparam int M_USED_W  = 4 * BANK_W + 2 * 32 + MIRROR_W + 1;

    // Upper address nibble regions
    localparam logic [3:0] REG_PRG01     = 4'h8;
    localparam logic [3:0] REG_PRG2      = 4'h9;
    localparam logic [3:0] REG_CHR_FIRST = 4'hA;
    localparam logic [3:0] REG_CHR_LAST  = 4'hD;
    localparam logic [3:0] REG_RELOAD    = 4'hE;
    localparam logic [3:0] REG_CTRL      = 4'hF;

    // Low address bits within the control region
    localparam logic [1:0] SUB_LOAD   = 2'd0;
    localparam logic [1:0] SUB_CTRL   = 2'd1;
    localparam logic [1:0] SUB_MIRROR = 2'd2;

    // Counter width selections
    localparam logic [WSEL_W-1:0] WSEL_4  = 2'd0;
    localparam logic [WSEL_W-1:0] WSEL_8  = 2'd1;
    localparam logic [WSEL_W-1:0] WSEL_12 = 2'd2;
    localparam logic [WSEL_W-1:0] WSEL_16 = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] value;
        logic [CYC_W-1:0]  cycles;
    } t_item;

    typedef struct packed {
        logic              tick;
        logic [CYC_W-1:0]  cycles;
        logic              load_count;
        logic              set_ctrl;
        logic              enable;
        logic [WSEL_W-1:0] width_sel;
        logic              set_reload;
        logic [1:0]        reload_idx;
        logic [NIB_W-1:0]  nibble;
    } t_irq_req;

    function automatic logic [CNT_W-1:0] width_mask(input logic [WSEL_W-1:0] sel);
        logic [CNT_W-1:0] m;
        case (sel)
            WSEL_4:  m = 16'h000F;
            WSEL_8:  m = 16'h00FF;
            WSEL_12: m = 16'h0FFF;
            default: m = 16'hFFFF;
        endcase
        return m;
    endfunction

    function automatic logic [UNITS_W-1:0] tick_units(input logic [ACC_W-1:0] acc);
        logic [UNITS_W-1:0] u;
        u = '0;
        for (int k = 1; k <= UNITS_MAX; k++) begin
            if (int'(acc) >= k * TICKS_PER_COUNT) begin
                u = u + 1'b1;
            end
        end
        return u;
    endfunction

    function automatic logic [BANK_W-1:0] set_nibble(input logic [BANK_W-1:0] old,
                                                     input logic              high,
                                                     input logic [NIB_W-1:0]  nib);
        logic [BANK_W-1:0] r;
        if (high) begin
            r = {nib, old[NIB_W-1:0]};
        end else begin
            r = {old[BANK_W-1:NIB_W], nib};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bmirq_in_stage.sv =====
// ----------------------------------------------------------------------------
// Bank mapper input stage
// Registers one incoming request and holds it until the update stage takes it.
// ----------------------------------------------------------------------------
module bmirq_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bmirq_pkg::t_item i_item,
    input  logic            i_advance,
    output logic            o_valid,
    output bmirq_pkg::t_item o_item
);
    import bmirq_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;

    assign o_ready = !r_valid || i_advance;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/bmirq_bank_regs.sv =====
// ----------------------------------------------------------------------------
// Bank mapper bank registers
// Decodes bus write requests, holds the program, character and mirroring
// registers and passes counter requests on to the interrupt counter.
// ----------------------------------------------------------------------------
module bmirq_bank_regs (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_en,
    input  bmirq_pkg::t_item                                      i_item,
    output logic [bmirq_pkg::PRG_BANKS-1:0][bmirq_pkg::BANK_W-1:0] o_prg,
    output logic [bmirq_pkg::CHR_BANKS-1:0][bmirq_pkg::BANK_W-1:0] o_chr,
    output logic [bmirq_pkg::MIRROR_W-1:0]                         o_mirror,
    output bmirq_pkg::t_irq_req                                   o_irq_req
);
    import bmirq_pkg::*;

    logic [PRG_BANKS-1:0][BANK_W-1:0] r_prg;
    logic [PRG_BANKS-1:0][BANK_W-1:0] n_prg;
    logic [CHR_BANKS-1:0][BANK_W-1:0] r_chr;
    logic [CHR_BANKS-1:0][BANK_W-1:0] n_chr;
    logic [MIRROR_W-1:0]              r_mirror;
    logic [MIRROR_W-1:0]              n_mirror;

    logic             wr;
    logic [3:0]       region;
    logic             hi_nib;
    logic [1:0]       sub;
    logic [NIB_W-1:0] nib;
    logic [3:0]       chr_off;
    logic [CHR_IDX_W-1:0] chr_idx;
    logic [1:0]       prg_idx;
    logic [DATA_W-1:0] val;
    logic [WSEL_W-1:0] wsel;

    assign wr      = i_en && !i_item.mode && i_item.address[ADDR_W-1];
    assign region  = i_item.address[ADDR_W-1:ADDR_W-4];
    assign sub     = i_item.address[1:0];
    assign hi_nib  = i_item.address[0];
    assign val     = i_item.value;
    assign nib     = val[NIB_W-1:0];
    assign chr_off = region - REG_CHR_FIRST;
    assign chr_idx = {chr_off[1:0], i_item.address[1]};
    assign prg_idx = {1'b0, i_item.address[1]};

    always_comb begin
        if (val[3]) begin
            wsel = WSEL_4;
        end else if (val[2]) begin
            wsel = WSEL_8;
        end else if (val[1]) begin
            wsel = WSEL_12;
        end else begin
            wsel = WSEL_16;
        end
    end

    always_comb begin
        n_prg    = r_prg;
        n_chr    = r_chr;
        n_mirror = r_mirror;

        o_irq_req            = '0;
        o_irq_req.tick       = i_en && i_item.mode;
        o_irq_req.cycles     = i_item.cycles;
        o_irq_req.enable     = val[0];
        o_irq_req.width_sel  = wsel;
        o_irq_req.reload_idx = sub;
        o_irq_req.nibble     = nib;

        if (wr) begin
            if (region == REG_PRG01) begin
                n_prg[prg_idx] = set_nibble(r_prg[prg_idx], hi_nib, nib);
            end else if (region == REG_PRG2) begin
                if (!i_item.address[1]) begin
                    n_prg[2] = set_nibble(r_prg[2], hi_nib, nib);
                end
            end else if (region >= REG_CHR_FIRST && region <= REG_CHR_LAST) begin
                n_chr[chr_idx] = set_nibble(r_chr[chr_idx], hi_nib, nib);
            end else if (region == REG_RELOAD) begin
                o_irq_req.set_reload = 1'b1;
            end else begin
                case (sub)
                    SUB_LOAD:   o_irq_req.load_count = 1'b1;
                    SUB_CTRL:   o_irq_req.set_ctrl   = 1'b1;
                    SUB_MIRROR: n_mirror             = val[MIRROR_W-1:0];
                    default:    n_mirror             = r_mirror;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg    <= '0;
            r_chr    <= '0;
            r_mirror <= '0;
        end else begin
            r_prg    <= n_prg;
            r_chr    <= n_chr;
            r_mirror <= n_mirror;
        end
    end

    assign o_prg    = r_prg;
    assign o_chr    = r_chr;
    assign o_mirror = r_mirror;

endmodule

// ===== hw/rtl/bmirq_irq_counter.sv =====
// ----------------------------------------------------------------------------
// Bank mapper interrupt counter
// Prescaler, reload value and width-masked down counter that raises the
// interrupt line when the masked part of the counter underflows.
// ----------------------------------------------------------------------------
module bmirq_irq_counter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bmirq_pkg::t_irq_req i_req,
    output logic                o_irq
);
    import bmirq_pkg::*;

    logic [CNT_W-1:0]      r_reload;
    logic [CNT_W-1:0]      n_reload;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [WSEL_W-1:0]     r_width_sel;
    logic [WSEL_W-1:0]     n_width_sel;
    logic                  r_enable;
    logic                  n_enable;
    logic [PRESCALE_W-1:0] r_prescale;
    logic [PRESCALE_W-1:0] n_prescale;
    logic                  r_irq;
    logic                  n_irq;

    logic [CNT_W-1:0]   mask;
    logic [CNT_W-1:0]   masked;
    logic [CNT_W-1:0]   low;
    logic [ACC_W-1:0]   acc;
    logic [UNITS_W-1:0] units;
    logic [ACC_W-1:0]   rem;
    logic               underflow;

    assign mask      = width_mask(r_width_sel);
    assign masked    = r_count & mask;
    assign acc       = ACC_W'(r_prescale) + ACC_W'(i_req.cycles);
    assign units     = tick_units(acc);
    assign rem       = acc - ACC_W'(int'(units) * TICKS_PER_COUNT);
    assign low       = (masked - CNT_W'(units)) & mask;
    assign underflow = masked < CNT_W'(units);

    always_comb begin
        n_reload    = r_reload;
        n_count     = r_count;
        n_width_sel = r_width_sel;
        n_enable    = r_enable;
        n_prescale  = r_prescale;
        n_irq       = r_irq;

        if (i_req.tick && r_enable) begin
            n_prescale = PRESCALE_W'(rem);
            n_count    = (r_count & ~mask) | low;
            n_irq      = r_irq || underflow;
        end
        if (i_req.set_reload) begin
            n_reload[i_req.reload_idx*NIB_W +: NIB_W] = i_req.nibble;
        end
        if (i_req.load_count) begin
            n_count = r_reload;
            n_irq   = 1'b0;
        end
        if (i_req.set_ctrl) begin
            n_enable    = i_req.enable;
            n_width_sel = i_req.width_sel;
            n_irq       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload    <= '0;
            r_count     <= '0;
            r_width_sel <= WSEL_16;
            r_enable    <= 1'b0;
            r_prescale  <= '0;
            r_irq       <= 1'b0;
        end else begin
            r_reload    <= n_reload;
            r_count     <= n_count;
            r_width_sel <= n_width_sel;
            r_enable    <= n_enable;
            r_prescale  <= n_prescale;
            r_irq       <= n_irq;
        end
    end

    assign o_irq = r_irq;

endmodule

// ===== hw/rtl/bank_mapper_with_irq_counter_unit.sv =====
// ----------------------------------------------------------------------------
// Bank mapper with interrupt counter
// Top level: stream ports, APB page count register and the result register.
// ----------------------------------------------------------------------------
// Each accepted request (a bus write or a tick of elapsed cycles) produces
// exactly one result carrying the full bank mapping, mirroring and interrupt
// line as they stand after that request. A request is registered on entry and
// applied to the mapping and counter registers when the output can advance,
// and these then hold the result until it is taken. The block accepts one
// request every cycle while the output is not stalled. The page count register
// should only be written while no request is in flight.
module bank_mapper_with_irq_counter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave side
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // address [15:0], value [23:16], cycles [27:24], zero fill [31:28]
    input  logic [bmirq_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // mode [0]
    input  logic                            i_s_axis_tuser,
    // Master side
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // prg_bank_8000 [7:0], prg_bank_a000 [15:8], prg_bank_c000 [23:16],
    // prg_bank_e000 [31:24], chr_banks_low [63:32], chr_banks_high [95:64],
    // mirroring [97:96], irq_line [98], zero fill [103:99]
    output logic [bmirq_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import bmirq_pkg::*;

    localparam logic [2:0] ADDR_PAGE_COUNT = 3'd0;

    t_item    in_item;
    t_item    st_item;
    logic     st_valid;
    logic     advance;
    logic     fire;
    t_irq_req irq_req;
    logic     irq;

    logic [PRG_BANKS-1:0][BANK_W-1:0] prg;
    logic [CHR_BANKS-1:0][BANK_W-1:0] chr;
    logic [MIRROR_W-1:0]              mirror;

    logic              r_out_valid;
    logic [PAGE_W-1:0] r_page_count;
    logic [PAGE_W-1:0] n_page_count;
    logic [BANK_W-1:0] last_bank;

    assign in_item.mode    = i_s_axis_tuser;
    assign in_item.address = i_s_axis_tdata[15:0];
    assign in_item.value   = i_s_axis_tdata[23:16];
    assign in_item.cycles  = i_s_axis_tdata[27:24];

    assign advance = !r_out_valid || i_m_axis_tready;
    assign fire    = st_valid && advance;

    bmirq_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (st_valid),
        .o_item    (st_item)
    );

    bmirq_bank_regs u_bank_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (fire),
        .i_item    (st_item),
        .o_prg     (prg),
        .o_chr     (chr),
        .o_mirror  (mirror),
        .o_irq_req (irq_req)
    );

    bmirq_irq_counter u_irq_counter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (irq_req),
        .o_irq   (irq)
    );

    always_comb begin
        n_page_count = r_page_count;
        if (psel && penable && pwrite && pready && paddr == ADDR_PAGE_COUNT) begin
            n_page_count = pwdata[PAGE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_page_count <= PAGE_RESET;
        end else begin
            r_page_count <= n_page_count;
            if (advance) begin
                r_out_valid <= st_valid;
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_PAGE_COUNT) ? {{(32 - PAGE_W){1'b0}}, r_page_count} : '0;

    assign last_bank = BANK_W'(r_page_count - PAGE_W'(1));

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, irq, mirror,
                              chr[7], chr[6], chr[5], chr[4],
                              chr[3], chr[2], chr[1], chr[0],
                              last_bank, prg[2], prg[1], prg[0]};

endmodule
